// ===== rtl/bldq_pkg.sv =====
// bldq_pkg: shared types, sizes and slot arithmetic for the bounded deque engine
// no dependencies; used by the channel interfaces and by bounded_list_deque_engine_core
package bldq_pkg;

	localparam int CAPACITY     = 32;
	localparam int RESULT_LIMIT = 32;
	localparam int VAL_W        = 32;
	localparam int REQ_W        = 3;
	localparam int LEN_W        = 6;
	localparam int STAT_W       = 2;
	localparam int SLOT_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int ADDR_W       = SLOT_W + 1;
	localparam int MEM_DEPTH    = 2 ** ADDR_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_REVERSE    = 3'd4,
		REQ_DROP_ALT   = 3'd5,
		REQ_READ_ALL   = 3'd6,
		REQ_LENGTH     = 3'd7
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_DATA,
		ST_WALK_RD,
		ST_WALK_OUT,
		ST_DROP_RD,
		ST_DROP_WR,
		ST_FINISH
	} state_t;

	// sum of two values each below CAPACITY, folded back into the ring
	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] sum);
		logic [CNT_W:0] folded;
		folded = (sum >= (CNT_W+1)'(CAPACITY)) ? sum - (CNT_W+1)'(CAPACITY) : sum;
		return folded[SLOT_W-1:0];
	endfunction

	// physical slot of a logical position, honoring the direction bit
	function automatic logic [SLOT_W-1:0] slot_of(
		input logic [SLOT_W-1:0] front,
		input logic [CNT_W-1:0]  count,
		input logic              rev,
		input logic [CNT_W:0]    idx
	);
		logic [CNT_W:0] off;
		off = rev ? ({1'b0, count} - (CNT_W+1)'(1) - idx) : idx;
		return wrap_slot((CNT_W+1)'(front) + off);
	endfunction

endpackage

// ===== rtl/bldq_if.sv =====
// request and response channel interfaces for the bounded deque engine
// depends on bldq_pkg for field widths
interface bldq_req_if;
	logic                                valid;
	logic                                ready;
	logic        [bldq_pkg::REQ_W-1:0]   req_type;
	logic signed [bldq_pkg::VAL_W-1:0]   value_in;

	modport source (output valid, output req_type, output value_in, input ready);
	modport sink   (input valid, input req_type, input value_in, output ready);
endinterface

interface bldq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [bldq_pkg::VAL_W-1:0]   value_out;
	logic        [bldq_pkg::LEN_W-1:0]   length;
	logic        [bldq_pkg::STAT_W-1:0]  status;
	logic                                last;

	modport source (output valid, output value_out, output length, output status, output last,
		input ready);
	modport sink   (input valid, input value_out, input length, input status, input last,
		output ready);
endinterface

// ===== rtl/bounded_list_deque_engine_core.sv =====
// bounded_list_deque_engine_core: deque of signed values in a two-bank ring memory
// depends on bldq_pkg and the bldq_req_if / bldq_rsp_if channel interfaces
// results: push, reverse, length and errors from ST_EXEC, pop from ST_POP_DATA,
// read-all from ST_WALK_OUT after each ST_WALK_RD, drop-alternate from ST_FINISH
// one transaction at a time: the next is taken once the last result is in the output
// register, so a new request waits until the last is through; arst_n leaves memory as is
module bounded_list_deque_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	bldq_req_if.sink   req,
	bldq_rsp_if.source rsp
);

	bldq_pkg::state_t                   state_q, state_d;
	bldq_pkg::req_t                     req_q;
	logic [bldq_pkg::VAL_W-1:0]         value_q;

	logic [bldq_pkg::SLOT_W-1:0]        front_q, front_d;
	logic [bldq_pkg::CNT_W-1:0]         count_q, count_d;
	logic                               rev_q, rev_d;
	logic                               bank_q, bank_d;
	logic [bldq_pkg::CNT_W:0]           idx_q, idx_d;
	logic [bldq_pkg::SLOT_W-1:0]        wr_idx_q, wr_idx_d;

	logic [bldq_pkg::VAL_W-1:0]         mem [bldq_pkg::MEM_DEPTH];
	logic                               mem_we, mem_re;
	logic [bldq_pkg::ADDR_W-1:0]        mem_waddr, mem_raddr;
	logic [bldq_pkg::VAL_W-1:0]         mem_wdata;
	logic [bldq_pkg::VAL_W-1:0]         rd_data_q;

	logic                               out_valid_q;
	logic [bldq_pkg::VAL_W-1:0]         out_value_q, out_value;
	logic [bldq_pkg::LEN_W-1:0]         out_length_q;
	bldq_pkg::status_t                  out_status_q, out_status;
	logic                               out_last_q, out_last;
	logic                               out_ld, out_free;

	logic                               in_take;
	logic                               at_front, phys_front, is_empty, is_full;
	logic [bldq_pkg::SLOT_W-1:0]        front_dec, front_inc, tail_slot, back_slot, walk_slot;
	logic [bldq_pkg::CNT_W-1:0]         walk_n;
	logic                               walk_last;

	assign req.ready = (state_q == bldq_pkg::ST_IDLE);
	assign in_take   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign at_front   = (req_q == bldq_pkg::REQ_PUSH_FRONT) || (req_q == bldq_pkg::REQ_POP_FRONT);
	assign phys_front = at_front != rev_q;
	assign is_empty   = (count_q == '0);
	assign is_full    = (count_q == bldq_pkg::CNT_W'(bldq_pkg::CAPACITY));

	assign front_dec = (front_q == '0) ? bldq_pkg::SLOT_W'(bldq_pkg::CAPACITY - 1)
		: front_q - bldq_pkg::SLOT_W'(1);
	assign front_inc = (front_q == bldq_pkg::SLOT_W'(bldq_pkg::CAPACITY - 1)) ? '0
		: front_q + bldq_pkg::SLOT_W'(1);
	assign tail_slot = bldq_pkg::wrap_slot((bldq_pkg::CNT_W+1)'(front_q)
		+ (bldq_pkg::CNT_W+1)'(count_q));
	assign back_slot = bldq_pkg::wrap_slot((bldq_pkg::CNT_W+1)'(front_q)
		+ (bldq_pkg::CNT_W+1)'(count_q) - (bldq_pkg::CNT_W+1)'(1));
	assign walk_slot = bldq_pkg::slot_of(front_q, count_q, rev_q, idx_q);

	// read-all is capped at the per-request result limit
	assign walk_n    = (count_q < bldq_pkg::CNT_W'(bldq_pkg::RESULT_LIMIT)) ? count_q
		: bldq_pkg::CNT_W'(bldq_pkg::RESULT_LIMIT);
	assign walk_last = ((idx_q + (bldq_pkg::CNT_W+1)'(1)) == {1'b0, walk_n});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bldq_pkg::ST_IDLE: begin
				if (in_take) state_d = bldq_pkg::ST_EXEC;
			end
			bldq_pkg::ST_EXEC: begin
				case (req_q)
					bldq_pkg::REQ_POP_FRONT, bldq_pkg::REQ_POP_BACK: begin
						if (!is_empty) state_d = bldq_pkg::ST_POP_DATA;
						else if (out_free) state_d = bldq_pkg::ST_IDLE;
					end
					bldq_pkg::REQ_DROP_ALT: begin
						if (!is_empty) state_d = bldq_pkg::ST_DROP_RD;
						else if (out_free) state_d = bldq_pkg::ST_IDLE;
					end
					bldq_pkg::REQ_READ_ALL: begin
						if (!is_empty) state_d = bldq_pkg::ST_WALK_RD;
						else if (out_free) state_d = bldq_pkg::ST_IDLE;
					end
					default: begin
						if (out_free) state_d = bldq_pkg::ST_IDLE;
					end
				endcase
			end
			bldq_pkg::ST_POP_DATA: begin
				if (out_free) state_d = bldq_pkg::ST_IDLE;
			end
			bldq_pkg::ST_WALK_RD: begin
				state_d = bldq_pkg::ST_WALK_OUT;
			end
			bldq_pkg::ST_WALK_OUT: begin
				if (out_free) state_d = walk_last ? bldq_pkg::ST_IDLE : bldq_pkg::ST_WALK_RD;
			end
			bldq_pkg::ST_DROP_RD: begin
				state_d = bldq_pkg::ST_DROP_WR;
			end
			bldq_pkg::ST_DROP_WR: begin
				if (idx_q >= (bldq_pkg::CNT_W+1)'(count_q)) state_d = bldq_pkg::ST_FINISH;
			end
			bldq_pkg::ST_FINISH: begin
				if (out_free) state_d = bldq_pkg::ST_IDLE;
			end
			default: state_d = bldq_pkg::ST_IDLE;
		endcase
	end

	// datapath control and next values of the bookkeeping registers
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = {bank_q, tail_slot};
		mem_wdata  = value_q;
		mem_re     = 1'b0;
		mem_raddr  = {bank_q, walk_slot};
		out_ld     = 1'b0;
		out_value  = '0;
		out_status = bldq_pkg::STAT_OK;
		out_last   = 1'b1;
		front_d    = front_q;
		count_d    = count_q;
		rev_d      = rev_q;
		bank_d     = bank_q;
		idx_d      = idx_q;
		wr_idx_d   = wr_idx_q;
		case (state_q)
			bldq_pkg::ST_EXEC: begin
				case (req_q)
					bldq_pkg::REQ_PUSH_FRONT, bldq_pkg::REQ_PUSH_BACK: begin
						out_ld = out_free;
						if (is_full) begin
							out_status = bldq_pkg::STAT_FULL;
						end else if (out_free) begin
							mem_we = 1'b1;
							if (phys_front) begin
								mem_waddr = {bank_q, front_dec};
								front_d   = front_dec;
							end
							count_d = count_q + bldq_pkg::CNT_W'(1);
						end
					end
					bldq_pkg::REQ_POP_FRONT, bldq_pkg::REQ_POP_BACK: begin
						if (is_empty) begin
							out_ld     = out_free;
							out_status = bldq_pkg::STAT_EMPTY;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = {bank_q, phys_front ? front_q : back_slot};
							if (phys_front) front_d = front_inc;
							count_d = count_q - bldq_pkg::CNT_W'(1);
						end
					end
					bldq_pkg::REQ_REVERSE: begin
						out_ld = out_free;
						if (out_free) rev_d = !rev_q;
					end
					bldq_pkg::REQ_DROP_ALT, bldq_pkg::REQ_READ_ALL: begin
						if (is_empty) begin
							out_ld     = out_free;
							out_status = bldq_pkg::STAT_EMPTY;
						end else begin
							idx_d    = '0;
							wr_idx_d = '0;
						end
					end
					default: begin
						out_ld = out_free;
					end
				endcase
			end
			bldq_pkg::ST_POP_DATA: begin
				out_ld    = out_free;
				out_value = rd_data_q;
			end
			bldq_pkg::ST_WALK_RD: begin
				mem_re = 1'b1;
			end
			bldq_pkg::ST_WALK_OUT: begin
				out_ld    = out_free;
				out_value = rd_data_q;
				out_last  = walk_last;
				if (out_free) idx_d = idx_q + (bldq_pkg::CNT_W+1)'(1);
			end
			bldq_pkg::ST_DROP_RD: begin
				mem_re = 1'b1;
				idx_d  = idx_q + (bldq_pkg::CNT_W+1)'(2);
			end
			bldq_pkg::ST_DROP_WR: begin
				// compacted copy goes to the other bank, so the drop's own reads never see it
				mem_we    = 1'b1;
				mem_waddr = {!bank_q, wr_idx_q};
				mem_wdata = rd_data_q;
				wr_idx_d  = wr_idx_q + bldq_pkg::SLOT_W'(1);
				if (idx_q < (bldq_pkg::CNT_W+1)'(count_q)) begin
					mem_re = 1'b1;
					idx_d  = idx_q + (bldq_pkg::CNT_W+1)'(2);
				end else begin
					front_d = '0;
					count_d = bldq_pkg::CNT_W'(wr_idx_q) + bldq_pkg::CNT_W'(1);
					rev_d   = 1'b0;
					bank_d  = !bank_q;
				end
			end
			bldq_pkg::ST_FINISH: begin
				out_ld = out_free;
			end
			default: begin
				out_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bldq_pkg::ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			wr_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			count_q  <= count_d;
			rev_q    <= rev_d;
			bank_q   <= bank_d;
			idx_q    <= idx_d;
			wr_idx_q <= wr_idx_d;
			if (out_ld) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q   <= bldq_pkg::req_t'(req.req_type);
			value_q <= req.value_in;
		end
		if (out_ld) begin
			out_value_q  <= out_value;
			out_length_q <= bldq_pkg::LEN_W'(count_d);
			out_status_q <= out_status;
			out_last_q   <= out_last;
		end
	end

	// element memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_raddr];
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.length    = out_length_q;
	assign rsp.status    = out_status_q;
	assign rsp.last      = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bldq_pkg::CNT_W'(bldq_pkg::CAPACITY))
		else $error("element count above capacity");

	a_no_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("memory read and write collide on one entry");

	a_take_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == bldq_pkg::ST_EXEC))
		else $error("accepted transaction not executed");

	a_drop_layout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bldq_pkg::ST_DROP_WR && state_d == bldq_pkg::ST_FINISH)
		|=> (front_q == '0 && !rev_q && count_q != '0))
		else $error("drop did not leave a natural-order layout from slot zero");
`endif

endmodule
